// ===== rtl/psl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional sequential list package
// Shared sizes, command codes and the control bundle that feeds each cell.
// ----------------------------------------------------------------------------
package psl_pkg;

  // Number of entries held in the cell chain.
  localparam int CAPACITY = 32;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int CMD_W  = 2;
  localparam int CNT_W  = 6;

  // Length register holds 0..CAPACITY.
  localparam int LEN_W = $clog2(CAPACITY + 1);

  // Width used for position compares; it must hold CAPACITY + 1 and any position.
  localparam int CMP_RAW_W = $clog2(CAPACITY + 2);
  localparam int CMP_W     = (CMP_RAW_W > POS_W) ? CMP_RAW_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_RSVD   = 2'd3
  } psl_cmd_t;

  // Broadcast to every cell in the chain for one request.
  typedef struct packed {
    logic                     ins_en;
    logic                     del_en;
    logic [CMP_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } psl_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/positional_sequential_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional sequential list
// Bounded ordered list of signed words with read, insert and delete by position.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   It carries command (read, insert, delete), a one-based position and, for
//   insert, a value. Exactly one result follows: done is high for a single
//   cycle, the cycle right after the request, with status (0 ok, 1 error),
//   element (value read or removed, zero otherwise) and count (length after
//   the request). The receiver cannot hold results off; they must be taken
//   in the cycle that done marks.
// Throughput:
//   One request per clock. The list is a chain of identical cells, one entry
//   each, and every cell shifts from its left or right neighbor in the same
//   cycle, so an insert or delete anywhere never holds up the next request.
//   Read data comes from the addressed cell's tap through an OR tree over the
//   chain. busy therefore never rises.
// Reset:
//   rst clears the length to zero (empty list) and drops done. Cell contents
//   are not cleared; no entry is read before it has been written.
// ----------------------------------------------------------------------------
module positional_sequential_list (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire  [psl_pkg::CMD_W-1:0]          command,
  input  wire  [psl_pkg::POS_W-1:0]          position,
  input  wire  signed [psl_pkg::DATA_W-1:0]  value,
  output logic                               done,
  output logic                               status,
  output logic signed [psl_pkg::DATA_W-1:0]  element,
  output logic [psl_pkg::CNT_W-1:0]          count
);

  localparam int CAP    = psl_pkg::CAPACITY;
  localparam int CMP_W  = psl_pkg::CMP_W;
  localparam int LEN_W  = psl_pkg::LEN_W;
  localparam int DATA_W = psl_pkg::DATA_W;

  logic [LEN_W-1:0]          len;
  logic [LEN_W-1:0]          len_next;
  logic                      accept;
  logic [CMP_W-1:0]          pos_ext;
  logic [CMP_W-1:0]          len_ext;
  logic                      pos_nonzero;
  logic                      read_ok;
  logic                      ins_ok;
  logic                      del_ok;
  logic                      req_ok;
  logic signed [DATA_W-1:0]  read_data;
  psl_pkg::psl_ctl_t         ctl;

  logic signed [DATA_W-1:0]  cell_data [CAP];
  logic signed [DATA_W-1:0]  cell_tap  [CAP];

  // No request ever has to wait, so requests are never refused.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_ext     = CMP_W'(position);
  assign len_ext     = CMP_W'(len);
  assign pos_nonzero = (position != '0);

  // Range checks. Insert also allows one past the end, which is an append.
  always_comb begin
    read_ok = 1'b0;
    ins_ok  = 1'b0;
    del_ok  = 1'b0;
    case (psl_pkg::psl_cmd_t'(command))
      psl_pkg::CMD_READ: begin
        read_ok = pos_nonzero && (pos_ext <= len_ext);
      end
      psl_pkg::CMD_INSERT: begin
        ins_ok = (len_ext < CMP_W'(CAP)) && pos_nonzero &&
                 (pos_ext <= (len_ext + CMP_W'(1)));
      end
      psl_pkg::CMD_DELETE: begin
        del_ok = pos_nonzero && (pos_ext <= len_ext);
      end
      default: begin
        read_ok = 1'b0;
      end
    endcase
  end

  assign req_ok = read_ok || ins_ok || del_ok;

  // Broadcast control: the chain only moves on an accepted, valid request.
  always_comb begin
    ctl.ins_en = accept && ins_ok;
    ctl.del_en = accept && del_ok;
    ctl.pos    = pos_ext;
    ctl.value  = value;
  end

  // The chain of cells. Each cell sees its left and right neighbor; the ends
  // see zero, which is never stored into a live entry.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    psl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .slot       (CMP_W'(i + 1)),
      .from_left  (left_in),
      .from_right (right_in),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // At most one tap is nonzero, so an OR picks the addressed entry.
  always_comb begin
    read_data = '0;
    for (int k = 0; k < CAP; k++) begin
      read_data = read_data | cell_tap[k];
    end
  end

  always_comb begin
    len_next = len;
    if (accept && ins_ok) begin
      len_next = len + LEN_W'(1);
    end else if (accept && del_ok) begin
      len_next = len - LEN_W'(1);
    end
  end

  // Length and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      done <= 1'b0;
    end else begin
      len  <= len_next;
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status  <= !req_ok;
      element <= (read_ok || del_ok) ? read_data : '0;
      count   <= psl_pkg::CNT_W'(len_next);
    end
  end

`ifndef SYNTHESIS
  // Every accepted request yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("request accepted without a result on the next cycle");

  // The length never passes the capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(CAP))
    else $error("list length above capacity");

  // An error result carries a zero element.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (element == '0))
    else $error("error result with nonzero element");

  // A good insert grows the list by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && ins_ok) |=> (len == ($past(len) + LEN_W'(1))))
    else $error("insert did not grow the list by one");
`endif

endmodule
`default_nettype wire

// ===== rtl/psl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional sequential list cell
// Holds one list entry and shifts with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module psl_cell (
  input  wire                                clk,
  input  wire  psl_pkg::psl_ctl_t            ctl,
  input  wire  [psl_pkg::CMP_W-1:0]          slot,
  input  wire  signed [psl_pkg::DATA_W-1:0]  from_left,
  input  wire  signed [psl_pkg::DATA_W-1:0]  from_right,
  output logic signed [psl_pkg::DATA_W-1:0]  data,
  output logic signed [psl_pkg::DATA_W-1:0]  tap
);

  logic hit;
  logic above;

  // slot is this cell's one-based position in the list.
  assign hit   = (slot == ctl.pos);
  assign above = (slot > ctl.pos);

  // Only the addressed cell drives its tap; the top level ORs all taps.
  assign tap = hit ? data : '0;

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (above) begin
        data <= from_left;
      end else if (hit) begin
        data <= ctl.value;
      end
    end else if (ctl.del_en) begin
      if (above || hit) begin
        data <= from_right;
      end
    end
  end

endmodule
`default_nettype wire
